// ----- src/irne_pkg.sv -----
// Shared types, constants and letter tables of the Roman numeral encoder.
// No dependencies; every module of the block imports this package.
package irne_pkg;

   localparam int unsigned VALUE_WIDTH = 12;
   localparam int unsigned DIGIT_WIDTH = 4;
   localparam int unsigned LETTER_WIDTH = 7;
   localparam int unsigned PLACES = 4;
   localparam int unsigned MULT_WIDTH = 14;
   localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = 12'd3999;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_EMIT,
      ST_ERROR
   } state_type;

   typedef enum logic [1:0] {
      KIND_ONE,
      KIND_FIVE,
      KIND_TEN
   } letter_kind_type;

   typedef struct packed {
      logic load;
      logic conv_step;
      logic skip;
      logic emit;
      logic emit_error;
   } command_type;

   typedef struct packed {
      logic value_zero;
      logic value_over;
      logic conv_last;
      logic digit_zero;
      logic final_letter;
      logic slot_free;
   } status_type;

   localparam logic [MULT_WIDTH-1:0] PLACE_WEIGHT [PLACES] = '{
      14'd1000, 14'd100, 14'd10, 14'd1
   };

   localparam logic [LETTER_WIDTH-1:0] LETTER_I = 7'd73;
   localparam logic [LETTER_WIDTH-1:0] LETTER_V = 7'd86;
   localparam logic [LETTER_WIDTH-1:0] LETTER_X = 7'd88;
   localparam logic [LETTER_WIDTH-1:0] LETTER_L = 7'd76;
   localparam logic [LETTER_WIDTH-1:0] LETTER_C = 7'd67;
   localparam logic [LETTER_WIDTH-1:0] LETTER_D = 7'd68;
   localparam logic [LETTER_WIDTH-1:0] LETTER_M = 7'd77;
   localparam logic [LETTER_WIDTH-1:0] LETTER_NONE = 7'd0;

   // Letters per place, most significant place first: one, five, ten.
   localparam logic [LETTER_WIDTH-1:0] PLACE_LETTERS [PLACES][3] = '{
      '{LETTER_M, LETTER_NONE, LETTER_NONE},
      '{LETTER_C, LETTER_D, LETTER_M},
      '{LETTER_X, LETTER_L, LETTER_C},
      '{LETTER_I, LETTER_V, LETTER_X}
   };

   function automatic logic [MULT_WIDTH-1:0] place_multiple(
      input logic [1:0] place,
      input logic [DIGIT_WIDTH-1:0] k
   );
      logic [2*MULT_WIDTH-1:0] product;
      product = PLACE_WEIGHT[place] * {{(MULT_WIDTH-DIGIT_WIDTH){1'b0}}, k};
      return product[MULT_WIDTH-1:0];
   endfunction

   function automatic logic [2:0] digit_len(input logic [DIGIT_WIDTH-1:0] d);
      logic [2:0] len;
      case (d)
         4'd1, 4'd5: len = 3'd1;
         4'd2, 4'd4, 4'd6, 4'd9: len = 3'd2;
         4'd3, 4'd7: len = 3'd3;
         4'd8: len = 3'd4;
         default: len = 3'd0;
      endcase
      return len;
   endfunction

   function automatic letter_kind_type letter_kind(
      input logic [DIGIT_WIDTH-1:0] d,
      input logic [1:0] pos
   );
      letter_kind_type kind;
      if (d == 4'd4) begin
         kind = (pos == 2'd0) ? KIND_ONE : KIND_FIVE;
      end else if (d == 4'd9) begin
         kind = (pos == 2'd0) ? KIND_ONE : KIND_TEN;
      end else if (d >= 4'd5 && pos == 2'd0) begin
         kind = KIND_FIVE;
      end else begin
         kind = KIND_ONE;
      end
      return kind;
   endfunction

endpackage

// ----- src/irne_ctrl.sv -----
// Controller state machine of the Roman numeral encoder.
// Depends on irne_pkg for the state, command and status types.
module irne_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  irne_pkg::status_type  status,
   output irne_pkg::command_type command
);
   import irne_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !status.value_zero) begin
               state_in = status.value_over ? ST_ERROR : ST_CONV;
            end
         end
         ST_CONV: begin
            if (status.conv_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!status.digit_zero && status.slot_free && status.final_letter) begin
               state_in = ST_IDLE;
            end
         end
         ST_ERROR: begin
            if (status.slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      command = '0;
      unique case (state_ff)
         ST_IDLE: command.load = accept;
         ST_CONV: command.conv_step = 1'b1;
         ST_EMIT: begin
            command.skip = status.digit_zero;
            command.emit = !status.digit_zero && status.slot_free;
         end
         ST_ERROR: command.emit_error = status.slot_free;
         default: command = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/irne_dp.sv -----
// Datapath of the Roman numeral encoder: digit extraction, letter
// sequencing and the result register. Depends on irne_pkg.
module irne_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [irne_pkg::VALUE_WIDTH-1:0]       value,
   input  irne_pkg::command_type                  command,
   output irne_pkg::status_type                   status,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [irne_pkg::LETTER_WIDTH-1:0]      rsp_letter,
   output logic                                   rsp_last,
   output logic                                   rsp_error
);
   import irne_pkg::*;

   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [1:0] place_ff, place_in;
   logic [1:0] pos_ff, pos_in;
   logic [DIGIT_WIDTH-1:0] digits_ff [PLACES];
   logic [DIGIT_WIDTH-1:0] digit_in;
   logic [MULT_WIDTH-1:0] taken;
   logic [DIGIT_WIDTH-1:0] cur_digit;
   logic [2:0] cur_len;
   logic digit_end;
   logic rest_zero;
   letter_kind_type kind;
   logic valid_ff, valid_in;
   logic [LETTER_WIDTH-1:0] letter_ff;
   logic last_ff, error_ff;

   always_comb begin
      digit_in = '0;
      for (int k = 1; k <= 9; k++) begin
         if ({2'b00, rem_ff} >= place_multiple(place_ff, DIGIT_WIDTH'(k))) begin
            digit_in = DIGIT_WIDTH'(k);
         end
      end
      taken = place_multiple(place_ff, digit_in);
      rem_in = rem_ff - taken[VALUE_WIDTH-1:0];
   end

   assign cur_digit = digits_ff[place_ff];
   assign cur_len = digit_len(cur_digit);
   assign digit_end = ({1'b0, pos_ff} == cur_len - 3'd1);
   assign kind = letter_kind(cur_digit, pos_ff);

   always_comb begin
      rest_zero = 1'b1;
      for (int q = 0; q < PLACES; q++) begin
         if (q > int'(place_ff) && digits_ff[q] != '0) begin
            rest_zero = 1'b0;
         end
      end
   end

   always_comb begin
      place_in = place_ff;
      pos_in = pos_ff;
      if (command.load) begin
         place_in = '0;
         pos_in = '0;
      end else if (command.conv_step || command.skip) begin
         place_in = place_ff + 2'd1;
      end else if (command.emit) begin
         if (digit_end) begin
            pos_in = '0;
            place_in = place_ff + 2'd1;
         end else begin
            pos_in = pos_ff + 2'd1;
         end
      end
   end

   assign status.value_zero = (value == '0);
   assign status.value_over = (value > VALUE_MAX);
   assign status.conv_last = (place_ff == 2'd3);
   assign status.digit_zero = (cur_digit == '0);
   assign status.final_letter = digit_end && rest_zero;
   assign status.slot_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (command.emit || command.emit_error) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         place_ff <= '0;
         pos_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         place_ff <= place_in;
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (command.load) begin
         rem_ff <= value;
      end else if (command.conv_step) begin
         rem_ff <= rem_in;
      end
      if (command.conv_step) begin
         digits_ff[place_ff] <= digit_in;
      end
      if (command.emit) begin
         letter_ff <= PLACE_LETTERS[place_ff][kind];
         last_ff <= digit_end && rest_zero;
         error_ff <= 1'b0;
      end else if (command.emit_error) begin
         letter_ff <= LETTER_NONE;
         last_ff <= 1'b1;
         error_ff <= 1'b1;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_letter = letter_ff;
   assign rsp_last = last_ff;
   assign rsp_error = error_ff;

endmodule

// ----- src/int_to_roman_numeral_encoder.sv -----
// Top level of the Roman numeral encoder: controller plus datapath.
// Depends on irne_pkg, irne_ctrl and irne_dp.
//
//   channel  direction  tdata                      tuser   tlast
//   req      in         value [11:0]               -       -
//   rsp      out        letter [6:0]               error   last letter
//
// A number is accepted, its four digits are extracted in turn through the
// shared compare-and-subtract unit, then its letters are emitted one by one
// and zero digits are skipped: up to fifteen letters per number. Zero gives no
// result; a value above 3999 gives one error result. Reset is synchronous
// and clears the state machine and the result valid. A stalled result holds
// its register and the letter sequencer waits.
module int_to_roman_numeral_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // value[11:0], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // letter[6:0], zero fill
   output logic        rsp_tlast,
   output logic [0:0]  rsp_tuser    // error
);
   import irne_pkg::*;

   command_type command;
   status_type status;
   logic [LETTER_WIDTH-1:0] letter;
   logic error;

   irne_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .command    (command)
   );

   irne_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .value      (req_tdata[VALUE_WIDTH-1:0]),
      .command    (command),
      .status     (status),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_letter (letter),
      .rsp_last   (rsp_tlast),
      .rsp_error  (error)
   );

   assign rsp_tdata = {1'b0, letter};
   assign rsp_tuser = error;

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for int_to_roman_numeral_encoder: it predicts the letter stream of each
// request and checks every result, with random idling on both channels.
// Depends on irne_pkg and the encoder RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import irne_pkg::*;

   typedef struct packed {
      logic [LETTER_WIDTH-1:0] letter;
      logic last;
      logic error;
   } roman_letter_type;

   class roman_scoreboard;
      roman_letter_type pending[$];
      int unsigned errors;

      function new();
         errors = 0;
      endfunction

      function void append_pending(roman_letter_type item);
         pending.insert(pending.size(), item);
      endfunction

      function void note_value(logic [VALUE_WIDTH-1:0] value);
         int unsigned digit[PLACES];
         int unsigned d;
         logic [LETTER_WIDTH-1:0] one, five, ten;
         if (value == '0) return;
         if (value > VALUE_MAX) begin
            append_pending('{LETTER_NONE, 1'b1, 1'b1});
            return;
         end
         digit[0] = value / 1000;
         digit[1] = (value / 100) % 10;
         digit[2] = (value / 10) % 10;
         digit[3] = value % 10;
         for (int p = 0; p < PLACES; p++) begin
            d = digit[p];
            one = PLACE_LETTERS[p][0];
            five = PLACE_LETTERS[p][1];
            ten = PLACE_LETTERS[p][2];
            if (d == 4) begin
               append_pending('{one, 1'b0, 1'b0});
               append_pending('{five, 1'b0, 1'b0});
            end else if (d == 9) begin
               append_pending('{one, 1'b0, 1'b0});
               append_pending('{ten, 1'b0, 1'b0});
            end else begin
               if (d >= 5) begin
                  append_pending('{five, 1'b0, 1'b0});
                  d = d - 5;
               end
               for (int i = 0; i < d; i++) append_pending('{one, 1'b0, 1'b0});
            end
         end
         pending[pending.size()-1].last = 1'b1;
      endfunction

      function void check_letter(logic [LETTER_WIDTH-1:0] letter, logic last, logic error);
         roman_letter_type want;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected result letter=%0d last=%b error=%b",
                     $time, letter, last, error);
            return;
         end
         want = pending.pop_front();
         if (letter !== want.letter || last !== want.last || error !== want.error) begin
            errors++;
            $display("%0t: mismatch expected letter=%0d last=%b error=%b, %s",
                     $time, want.letter, want.last, want.error, "got");
            $display("%0t:    actual letter=%0d last=%b error=%b",
                     $time, letter, last, error);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic [0:0]  rsp_tuser;

   roman_scoreboard numerals = new();
   bit steady = 1'b0;
   int unsigned stall_left = 0;

   int_to_roman_numeral_encoder dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser)
   );

   always #1 clock = ~clock;

   function automatic int unsigned pick_gap(bit calm);
      int unsigned r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] random_value();
      int unsigned r;
      int unsigned v;
      r = $urandom_range(0, 99);
      if (r < 6) return '0;
      if (r < 14) return VALUE_WIDTH'($urandom_range(4000, 4095));
      if (r < 26) begin
         v = $urandom_range(0, 3) * 1000;
         for (int p = 100; p >= 1; p = p / 10) begin
            case ($urandom_range(0, 3))
               0: v = v + 4 * p;
               1: v = v + 8 * p;
               2: v = v + 9 * p;
               default: v = v + $urandom_range(0, 9) * p;
            endcase
         end
         return (v == 0) ? 12'd1 : VALUE_WIDTH'(v);
      end
      return VALUE_WIDTH'($urandom_range(1, 3999));
   endfunction

   task automatic send_value(logic [VALUE_WIDTH-1:0] value);
      int unsigned gap;
      gap = pick_gap(steady);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0000, value};
      do @(posedge clock); while (!req_tready);
      numerals.note_value(value);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      int unsigned g;
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         g = pick_gap(steady);
         if (g > 0 && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = g - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         numerals.check_letter(rsp_tdata[LETTER_WIDTH-1:0], rsp_tlast, rsp_tuser[0]);
      end
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      logic [VALUE_WIDTH-1:0] directed[$];
      int unsigned waited;
      directed = '{12'd0, 12'd1, 12'd4, 12'd5, 12'd9, 12'd10, 12'd40, 12'd50, 12'd90,
                   12'd100, 12'd400, 12'd500, 12'd900, 12'd1000, 12'd3000, 12'd3888,
                   12'd3999, 12'd4000, 12'd4095, 12'd1994, 12'd2730, 12'd1365,
                   12'd2048, 12'd0, 12'd1111};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send_value(directed[i]);
      for (int n = 0; n < 200; n++) begin
         if (n % 40 == 0) steady = ($urandom_range(0, 2) == 0);
         send_value(random_value());
      end
      req_tvalid <= 1'b0;
      steady = 1'b0;
      waited = 0;
      while (numerals.pending.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (30) @(posedge clock);
      if (numerals.pending.size() != 0) begin
         numerals.errors += numerals.pending.size();
         $display("%0t: %0d expected letters never arrived", $time, numerals.pending.size());
      end
      if (numerals.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
